>>> rtl/mhc_pkg.sv
`default_nettype none

package mhc_pkg;

  // APB address width: eight 32-bit registers at byte addresses 4*i.
  localparam int unsigned AddrW = 5;

  // Register map, in word order.
  typedef enum logic [2:0] {
    REG_SMOOTHING = 3'd0,
    REG_OFFSET_X  = 3'd1,
    REG_OFFSET_Y  = 3'd2,
    REG_SOFT_XX   = 3'd3,
    REG_SOFT_XY   = 3'd4,
    REG_SOFT_YX   = 3'd5,
    REG_SOFT_YY   = 3'd6,
    REG_MODE      = 3'd7
  } mhc_reg_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic        [15:0] smoothing;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic signed [31:0] soft_xx;
    logic signed [31:0] soft_xy;
    logic signed [31:0] soft_yx;
    logic signed [31:0] soft_yy;
    logic               heading_mode;
  } mhc_cfg_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_CST,
    S_CWAIT,
    S_OUT
  } mhc_state_e;

  // Width of the corrected vector (Q.38 matrix product sum).
  localparam int unsigned VecW = 57;
  // CORDIC working width, with headroom for the CORDIC gain.
  localparam int unsigned CorW = 59;
  // Angle accumulator width, Q.24 radians.
  localparam int unsigned AngW = 28;

  localparam logic signed [AngW-1:0] Ang0   = 28'sd13176795;
  localparam logic signed [15:0]     PiQ13  = 16'sd25736;

  // Arctangent of 2^-i in Q.24; from step 8 on it equals 2^(24-i).
  function automatic logic signed [AngW-1:0] mhc_ang(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    case (i)
      5'd0:    r = Ang0;
      5'd1:    r = 28'sd7778716;
      5'd2:    r = 28'sd4110060;
      5'd3:    r = 28'sd2086331;
      5'd4:    r = 28'sd1047214;
      5'd5:    r = 28'sd524117;
      5'd6:    r = 28'sd262123;
      5'd7:    r = 28'sd131069;
      default: r = 28'sd1 <<< (5'd24 - i);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mhc_regs.sv
`default_nettype none

module mhc_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mhc_pkg::AddrW-1:0]   paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output mhc_pkg::mhc_cfg_t                cfg_o
);
  import mhc_pkg::*;

  mhc_cfg_t cfg_q;
  mhc_reg_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = mhc_reg_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  // Register writes; the field widths drop the unused upper data bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Identity soft-iron matrix, everything else cleared.
      cfg_q <= '{smoothing:    16'h0000,
                 offset_x:     24'sh000000,
                 offset_y:     24'sh000000,
                 soft_xx:      32'sh4000_0000,
                 soft_xy:      32'sh0000_0000,
                 soft_yx:      32'sh0000_0000,
                 soft_yy:      32'sh4000_0000,
                 heading_mode: 1'b0};
    end else if (wr_en) begin
      unique case (idx)
        REG_SMOOTHING: cfg_q.smoothing    <= pwdata[15:0];
        REG_OFFSET_X:  cfg_q.offset_x     <= pwdata[23:0];
        REG_OFFSET_Y:  cfg_q.offset_y     <= pwdata[23:0];
        REG_SOFT_XX:   cfg_q.soft_xx      <= pwdata;
        REG_SOFT_XY:   cfg_q.soft_xy      <= pwdata;
        REG_SOFT_YX:   cfg_q.soft_yx      <= pwdata;
        REG_SOFT_YY:   cfg_q.soft_yy      <= pwdata;
        REG_MODE:      cfg_q.heading_mode <= pwdata[0];
        default:       cfg_q              <= cfg_q;
      endcase
    end
  end

  // Read back, zero-extended to the bus width.
  always_comb begin
    unique case (idx)
      REG_SMOOTHING: prdata = {16'h0000, cfg_q.smoothing};
      REG_OFFSET_X:  prdata = {8'h00, cfg_q.offset_x};
      REG_OFFSET_Y:  prdata = {8'h00, cfg_q.offset_y};
      REG_SOFT_XX:   prdata = cfg_q.soft_xx;
      REG_SOFT_XY:   prdata = cfg_q.soft_xy;
      REG_SOFT_YX:   prdata = cfg_q.soft_yx;
      REG_SOFT_YY:   prdata = cfg_q.soft_yy;
      REG_MODE:      prdata = {31'h0, cfg_q.heading_mode};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/mhc_mul.sv
`default_nettype none

module mhc_mul (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [23:0] b_i,
  output logic signed      [55:0] p_o
);

  logic signed [55:0] p_q;

  // Shared signed multiplier with a registered product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

>>> rtl/mhc_cordic.sv
`default_nettype none

module mhc_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [mhc_pkg::VecW-1:0]   x_i,
  input  wire logic signed [mhc_pkg::VecW-1:0]   y_i,
  output logic                                   done_o,
  output logic signed      [15:0]                heading_o
);
  import mhc_pkg::*;

  localparam int unsigned StepW = $clog2(CORDIC_STEPS);

  logic                   busy_q, fin_q, zero_q;
  logic [StepW-1:0]       step_q;
  logic signed [CorW-1:0] x_q, y_q;
  logic signed [AngW-1:0] z_q;

  logic signed [CorW-1:0] xe, ye, x0, y0, xs, ys;
  logic signed [AngW-1:0] z0, ang, zr;
  logic                   last_step;

  assign xe = {{(CorW-VecW){x_i[VecW-1]}}, x_i};
  assign ye = {{(CorW-VecW){y_i[VecW-1]}}, y_i};

  // Quadrant pre-rotation by plus or minus pi/2 for a negative X.
  always_comb begin
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (xe[CorW-1]) begin
      if (!ye[CorW-1]) begin
        x0 = ye;
        y0 = -xe;
        z0 = Ang0 <<< 1;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -(Ang0 <<< 1);
      end
    end
  end

  // One vectoring step per cycle through the shared add/shift unit.
  assign xs        = x_q >>> step_q;
  assign ys        = y_q >>> step_q;
  assign ang       = mhc_ang(5'(step_q));
  assign last_step = (step_q == StepW'(CORDIC_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      step_q <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x0;
      y_q    <= y0;
      z_q    <= z0;
      zero_q <= (x_i == '0) && (y_i == '0);
    end else if (busy_q) begin
      if (!y_q[CorW-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang;
      end
    end
  end

  // Round Q.24 to Q3.13 and clamp to plus or minus pi.
  assign zr = (z_q + 28'sd1024) >>> 11;

  always_comb begin
    if (zero_q) begin
      heading_o = '0;
    end else if (zr > AngW'(PiQ13)) begin
      heading_o = PiQ13;
    end else if (zr < -AngW'(PiQ13)) begin
      heading_o = -PiQ13;
    end else begin
      heading_o = zr[15:0];
    end
  end

  assign done_o = fin_q;

endmodule

`default_nettype wire

>>> rtl/magnetometer_heading_correction.sv
// Channel   Direction  Transfer carries
// s_axis    in         one sample: x_high, x_low, y_high, y_low bytes
// m_axis    out        heading, smooth_x, smooth_y; tuser = heading_valid
// APB       in/out     eight configuration registers at byte address 4*i
//
// One shared 32x24 multiplier computes the products in turn: four products
// for the smoothing filter, four more for the soft-iron matrix in heading mode.
// In heading mode the CORDIC unit then turns the corrected vector into a heading.
// s_axis_tready is high only while idle; a result waits in the output register,
// which stalls the sequencer while still full. Reset clears the control, filter
// and heading state; the configuration resets to an identity soft-iron matrix.
`default_nettype none

module magnetometer_heading_correction #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // APB configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mhc_pkg::AddrW-1:0]  paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  // Samples in
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [31:0]                s_axis_tdata,  // x_high, x_low, y_high, y_low
  // Results out
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [63:0]                m_axis_tdata,  // heading, smooth_x, smooth_y
  output logic                            m_axis_tuser   // heading_valid
);
  import mhc_pkg::*;

  mhc_cfg_t   cfg;
  mhc_state_e state_q, state_d;
  logic [2:0] op_q, op_d;

  logic signed [15:0]     rx_q, ry_q;
  logic signed [23:0]     filt_x_q, filt_y_q;
  logic signed [15:0]     last_heading_q;
  logic                   hv_q;
  logic signed [VecW-1:0] acc_q, cx_q;
  logic                   m_valid_q;
  logic [63:0]            m_data_q;
  logic                   m_user_q;

  logic                   latch_in, mul_en, acc_en, cor_start, cor_done, load_out;
  logic [15:0]            a_eff, b_eff;
  logic signed [31:0]     mul_a;
  logic signed [23:0]     mul_b, dx, dy;
  logic signed [55:0]     prod;
  logic signed [VecW-1:0] sum, shr;
  logic signed [23:0]     filt_new;
  logic signed [15:0]     cor_heading;

  mhc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Saturate a wide signed value to 24 bits.
  function automatic logic signed [23:0] sat24(input logic signed [VecW-1:0] v);
    logic signed [23:0] r;
    if (v > 57'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -57'sd8388608) begin
      r = -24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Filter weights; a weight above one acts as one.
  assign a_eff = (cfg.smoothing > 16'd32768) ? 16'd32768 : cfg.smoothing;
  assign b_eff = 16'd32768 - a_eff;

  // Hard-iron offset removal on the smoothed values.
  assign dx = sat24(VecW'(filt_x_q) - VecW'(cfg.offset_x));
  assign dy = sat24(VecW'(filt_y_q) - VecW'(cfg.offset_y));

  // Operand selection for the shared multiplier.
  always_comb begin
    case (op_q)
      3'd0:    begin mul_a = {16'h0000, a_eff}; mul_b = filt_x_q;       end
      3'd1:    begin mul_a = {16'h0000, b_eff}; mul_b = {rx_q, 8'h00};  end
      3'd2:    begin mul_a = {16'h0000, a_eff}; mul_b = filt_y_q;       end
      3'd3:    begin mul_a = {16'h0000, b_eff}; mul_b = {ry_q, 8'h00};  end
      3'd4:    begin mul_a = cfg.soft_xx;       mul_b = dx;             end
      3'd5:    begin mul_a = cfg.soft_xy;       mul_b = dy;             end
      3'd6:    begin mul_a = cfg.soft_yx;       mul_b = dx;             end
      default: begin mul_a = cfg.soft_yy;       mul_b = dy;             end
    endcase
  end

  mhc_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Even products start a sum, odd ones complete it.
  assign sum      = (op_q[0] ? acc_q : '0) + {prod[55], prod};
  assign shr      = (sum + 57'sd16384) >>> 15;
  assign filt_new = sat24(shr);

  mhc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cor_start),
    .x_i       (cx_q),
    .y_i       (acc_q),
    .done_o    (cor_done),
    .heading_o (cor_heading)
  );

  // Sequencer: next state and control strobes.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    latch_in  = 1'b0;
    mul_en    = 1'b0;
    acc_en    = 1'b0;
    cor_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          latch_in = 1'b1;
          op_d     = '0;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        mul_en  = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_en = 1'b1;
        op_d   = op_q + 3'd1;
        if (op_q == 3'd3 && !cfg.heading_mode) begin
          state_d = S_OUT;
        end else if (op_q == 3'd7) begin
          state_d = S_CST;
        end else begin
          state_d = S_MUL;
        end
      end
      S_CST: begin
        cor_start = 1'b1;
        state_d   = S_CWAIT;
      end
      S_CWAIT: begin
        if (cor_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Filter state, heading state and output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_x_q       <= '0;
      filt_y_q       <= '0;
      last_heading_q <= '0;
      hv_q           <= 1'b0;
      m_valid_q      <= 1'b0;
    end else begin
      if (acc_en && op_q == 3'd1) begin
        filt_x_q <= filt_new;
      end
      if (acc_en && op_q == 3'd3) begin
        filt_y_q <= filt_new;
      end
      if (latch_in) begin
        hv_q <= 1'b0;
      end else if (cor_done) begin
        hv_q           <= 1'b1;
        last_heading_q <= cor_heading;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath payload registers.
  always_ff @(posedge clk_i) begin
    if (latch_in) begin
      rx_q <= {s_axis_tdata[7:0], s_axis_tdata[15:8]};
      ry_q <= {s_axis_tdata[23:16], s_axis_tdata[31:24]};
    end
    if (acc_en) begin
      acc_q <= sum;
      if (op_q == 3'd5) begin
        cx_q <= sum;
      end
    end
    if (load_out) begin
      m_data_q <= {filt_y_q, filt_x_q, last_heading_q};
      m_user_q <= hv_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // The CORDIC unit reports completion only while the sequencer waits on it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> state_q == S_CWAIT)
    else $error("CORDIC completion outside its wait state");

  // The last matrix product always hands over to the CORDIC unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACC && op_q == 3'd7 |=> state_q == S_CST)
    else $error("matrix sequence did not start the CORDIC unit");

  // A delivered heading stays within plus or minus pi.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= PiQ13
                   && $signed(m_axis_tdata[15:0]) >= -PiQ13)
    else $error("heading out of range");

  // A calibrate-mode result carries the heading held from before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && !hv_q |=> m_axis_tdata[15:0] == $past(last_heading_q))
    else $error("held heading changed in calibrate mode");

endmodule

`default_nettype wire

>>> tb/magnetometer_heading_checker.sv
`timescale 1ns / 1ps

module magnetometer_heading_checker #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Configuration port, observed only
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [mhc_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  input  wire logic                      pready,
  // Sample channel, observed only
  input  wire logic                      s_axis_tvalid,
  input  wire logic                      s_axis_tready,
  input  wire logic [31:0]               s_axis_tdata,  // x_high, x_low, y_high, y_low
  // Result channel, observed only
  input  wire logic                      m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  input  wire logic [63:0]               m_axis_tdata,  // heading, smooth_x, smooth_y
  input  wire logic                      m_axis_tuser,  // heading_valid
  output int                             errors_o,
  output int                             pending_o,
  output int                             results_o,
  output int                             headings_o
);

  import mhc_pkg::*;

  typedef struct packed {
    logic signed [15:0] heading;
    logic               heading_valid;
    logic signed [23:0] smooth_x;
    logic signed [23:0] smooth_y;
  } mag_result_t;

  // Local copy of the configuration registers.
  logic [15:0] cfg_smoothing;
  longint      cfg_off_x;
  longint      cfg_off_y;
  longint      cfg_xx;
  longint      cfg_xy;
  longint      cfg_yx;
  longint      cfg_yy;
  logic        cfg_heading_mode;

  // Local copy of the filter and heading state.
  longint             filt_x;
  longint             filt_y;
  logic signed [15:0] held_heading;

  mag_result_t heading_q[$];

  function automatic longint sat_q16_8(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Exponential smoother on one axis; raw is widened to Q16.8 first.
  function automatic longint smooth_axis(input longint prev, input longint raw,
                                         input longint wt);
    longint acc;
    acc = wt * prev + (64'sd32768 - wt) * (raw * 256) + 64'sd16384;
    return sat_q16_8(acc >>> 15);
  endfunction

  // Arctangent of 2^-k in Q.24 radians.
  function automatic longint atan_q24(input int k);
    case (k)
      0:       return 64'sd13176795;
      1:       return 64'sd7778716;
      2:       return 64'sd4110060;
      3:       return 64'sd2086331;
      4:       return 64'sd1047214;
      5:       return 64'sd524117;
      6:       return 64'sd262123;
      7:       return 64'sd131069;
      default: return 64'sd1 <<< (24 - k);
    endcase
  endfunction

  // CORDIC vectoring atan2(vy, vx), rounded to Q3.13 and clamped to +-pi.
  function automatic logic signed [15:0] cordic_heading(input longint vy, input longint vx);
    longint ang;
    longint tmp;
    longint xs;
    longint ys;
    longint h;
    int     steps;
    int     k;
    if (vx == 0 && vy == 0) return 16'sd0;
    steps = (CORDIC_STEPS > 25) ? 25 : CORDIC_STEPS;
    ang = 0;
    // Bring the left half plane into the right half by a quarter turn.
    if (vx < 0) begin
      tmp = vx;
      if (vy >= 0) begin
        vx = vy;
        vy = -tmp;
        ang = 2 * atan_q24(0);
      end else begin
        vx = -vy;
        vy = tmp;
        ang = -2 * atan_q24(0);
      end
    end
    for (k = 0; k < steps; k++) begin
      xs = vx >>> k;
      ys = vy >>> k;
      if (vy >= 0) begin
        vx = vx + ys;
        vy = vy - xs;
        ang = ang + atan_q24(k);
      end else begin
        vx = vx - ys;
        vy = vy + xs;
        ang = ang - atan_q24(k);
      end
    end
    h = (ang + 1024) >>> 11;
    if (h > 64'sd25736) h = 64'sd25736;
    if (h < -64'sd25736) h = -64'sd25736;
    return h[15:0];
  endfunction

  // Advances the local state by one sample and returns the expected result.
  function automatic mag_result_t predict_sample(input logic [31:0] d);
    mag_result_t r;
    longint      raw_x;
    longint      raw_y;
    longint      wt;
    longint      dx;
    longint      dy;
    longint      cx;
    longint      cy;
    raw_x = longint'($signed({d[7:0], d[15:8]}));
    raw_y = longint'($signed({d[23:16], d[31:24]}));
    // A weight above one behaves as exactly one.
    wt = (cfg_smoothing > 16'd32768) ? 64'sd32768 : longint'(cfg_smoothing);
    filt_x = smooth_axis(filt_x, raw_x, wt);
    filt_y = smooth_axis(filt_y, raw_y, wt);
    r.heading_valid = 1'b0;
    if (cfg_heading_mode) begin
      dx = sat_q16_8(filt_x - cfg_off_x);
      dy = sat_q16_8(filt_y - cfg_off_y);
      cx = cfg_xx * dx + cfg_xy * dy;
      cy = cfg_yx * dx + cfg_yy * dy;
      held_heading = cordic_heading(cy, cx);
      r.heading_valid = 1'b1;
    end
    r.heading = held_heading;
    r.smooth_x = filt_x[23:0];
    r.smooth_y = filt_y[23:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors_o++;
    $display("%0t ns: result %0d: %s is %0d, expected %0d",
             $time, results_o, what, got, want);
  endtask

  // Compares one result transfer against the oldest expectation.
  task automatic check_result();
    mag_result_t want;
    if (heading_q.size() == 0) begin
      report_mismatch("result with nothing outstanding, heading",
                      longint'($signed(m_axis_tdata[15:0])), 0);
    end else begin
      want = heading_q.pop_front();
      if (m_axis_tdata[15:0] !== want.heading)
        report_mismatch("heading", longint'($signed(m_axis_tdata[15:0])),
                        longint'(want.heading));
      if (m_axis_tuser !== want.heading_valid)
        report_mismatch("heading_valid", longint'(m_axis_tuser),
                        longint'(want.heading_valid));
      if (m_axis_tdata[39:16] !== want.smooth_x)
        report_mismatch("smooth_x", longint'($signed(m_axis_tdata[39:16])),
                        longint'(want.smooth_x));
      if (m_axis_tdata[63:40] !== want.smooth_y)
        report_mismatch("smooth_y", longint'($signed(m_axis_tdata[63:40])),
                        longint'(want.smooth_y));
      if (want.heading_valid) headings_o++;
    end
    results_o++;
  endtask

  // Track register writes, predict on sample transfers, check result transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_smoothing    = 16'd0;
      cfg_off_x        = 0;
      cfg_off_y        = 0;
      cfg_xx           = 64'sd1073741824;
      cfg_xy           = 0;
      cfg_yx           = 0;
      cfg_yy           = 64'sd1073741824;
      cfg_heading_mode = 1'b0;
      filt_x           = 0;
      filt_y           = 0;
      held_heading     = 16'sd0;
      heading_q.delete();
      errors_o         = 0;
      pending_o        = 0;
      results_o        = 0;
      headings_o       = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (mhc_reg_e'(paddr[4:2]))
          REG_SMOOTHING: cfg_smoothing    = pwdata[15:0];
          REG_OFFSET_X:  cfg_off_x        = longint'($signed(pwdata[23:0]));
          REG_OFFSET_Y:  cfg_off_y        = longint'($signed(pwdata[23:0]));
          REG_SOFT_XX:   cfg_xx           = longint'($signed(pwdata));
          REG_SOFT_XY:   cfg_xy           = longint'($signed(pwdata));
          REG_SOFT_YX:   cfg_yx           = longint'($signed(pwdata));
          REG_SOFT_YY:   cfg_yy           = longint'($signed(pwdata));
          REG_MODE:      cfg_heading_mode = pwdata[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) heading_q.push_back(predict_sample(s_axis_tdata));
      pending_o = heading_q.size();
    end
  end

endmodule

>>> tb/magnetometer_heading_correction_tb.sv
`timescale 1ns / 1ps

module magnetometer_heading_correction_tb;

  import mhc_pkg::*;

  localparam int unsigned Steps = 16;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;   // x_high, x_low, y_high, y_low
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [63:0]         m_axis_tdata;   // heading, smooth_x, smooth_y
  logic                m_axis_tuser;   // heading_valid

  int errors;
  int pending;
  int results;
  int headings;

  // Knobs and counters of the stimulus; rx_fast and rx_hold_req also steer the result-side process.
  bit tx_fast;
  bit rx_fast;
  bit rx_hold_req;
  int samples_sent;
  int settings_used;
  logic signed [23:0] cur_off_x;
  logic signed [23:0] cur_off_y;

  magnetometer_heading_correction #(
    .CORDIC_STEPS(Steps)
  ) dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  magnetometer_heading_checker #(
    .CORDIC_STEPS(Steps)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .errors_o(errors),
    .pending_o(pending),
    .results_o(results),
    .headings_o(headings)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run limit.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stalls, fast stretches, and one long hold-off on request.
  initial begin
    int rx_gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      rx_gap = rx_fast ? 0 : $urandom_range(0, 9);
      if (rx_gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // One register write: setup phase, access phase, then bus idle.
  task automatic reg_write(input mhc_reg_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one sample after a random gap and waits for its transfer.
  task automatic send_xy(input logic [15:0] x, input logic [15:0] y);
    int tx_gap;
    tx_gap = tx_fast ? 0 : $urandom_range(0, 9);
    if (tx_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (tx_gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y[7:0], y[15:8], x[7:0], x[15:8]};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    samples_sent++;
  endtask

  // Stops offering and waits until every outstanding result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly full-range values, some close to the hard-iron offset, some extremes.
  function automatic logic [15:0] pick_axis(input logic signed [23:0] off);
    logic [15:0] v;
    case ($urandom_range(0, 9))
      7, 8: v = off[23:8] + 16'($urandom_range(0, 16)) - 16'd8;
      9: begin
        case ($urandom_range(0, 3))
          0:       v = 16'h7FFF;
          1:       v = 16'h8000;
          2:       v = 16'hFFFF;
          default: v = 16'h0000;
        endcase
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 4))
      0:       return 32'hFF80_0000;
      1:       return 32'h007F_FFFF;
      2:       return 32'($signed($urandom_range(0, 8192)) - 4096);
      default: return 32'($signed($urandom) >>> 8);
    endcase
  endfunction

  function automatic logic [31:0] pick_matrix();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h4000_0000;
      3:       return 32'hC000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Writes a full register setting; the first two settings are the extremes.
  task automatic new_setting(input int ph);
    logic [31:0] sm;
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] mxx;
    logic [31:0] mxy;
    logic [31:0] myx;
    logic [31:0] myy;
    if (ph == 1) begin
      sm = 32'd32768;
      ox = 32'h007F_FFFF;
      oy = 32'h007F_FFFF;
      mxx = 32'h7FFF_FFFF;
      mxy = 32'h7FFF_FFFF;
      myx = 32'h7FFF_FFFF;
      myy = 32'h7FFF_FFFF;
    end else if (ph == 2) begin
      sm = 32'd0;
      ox = 32'hFF80_0000;
      oy = 32'hFF80_0000;
      mxx = 32'h8000_0000;
      mxy = 32'h8000_0000;
      myx = 32'h8000_0000;
      myy = 32'h8000_0000;
    end else begin
      case ($urandom_range(0, 5))
        0:       sm = 32'd0;
        1:       sm = 32'd32768;
        2:       sm = $urandom_range(32769, 65535);
        default: sm = $urandom_range(0, 32768);
      endcase
      ox = pick_offset();
      oy = pick_offset();
      mxx = pick_matrix();
      mxy = pick_matrix();
      myx = pick_matrix();
      myy = pick_matrix();
    end
    cur_off_x = ox[23:0];
    cur_off_y = oy[23:0];
    reg_write(REG_SMOOTHING, sm);
    reg_write(REG_OFFSET_X, ox);
    reg_write(REG_OFFSET_Y, oy);
    reg_write(REG_SOFT_XX, mxx);
    reg_write(REG_SOFT_XY, mxy);
    reg_write(REG_SOFT_YX, myx);
    reg_write(REG_SOFT_YY, myy);
    reg_write(REG_MODE, {31'd0, ph % 4 != 3});
    settings_used++;
  endtask

  // Stimulus and verdict.
  initial begin
    int ph;
    int n;
    rst_ni        = 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    tx_fast       = 1'b0;
    rx_fast       = 1'b0;
    rx_hold_req   = 1'b0;
    samples_sent  = 0;
    settings_used = 1;
    cur_off_x     = '0;
    cur_off_y     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting is calibrate mode: filter only, heading held at zero.
    send_xy(16'h0000, 16'h0000);
    send_xy(16'h7FFF, 16'h8000);
    send_xy(16'h8000, 16'h7FFF);
    send_xy(16'hFFFF, 16'h00FF);
    wait_drained();

    // Heading mode with identity matrix and no smoothing.
    reg_write(REG_MODE, 32'd1);
    settings_used++;
    send_xy(16'h0000, 16'h0000);   // zero vector
    send_xy(-16'sd100, 16'h0000);  // negative X on the axis gives +pi
    send_xy(16'd100, 16'h0000);
    send_xy(16'h0000, 16'd100);
    send_xy(16'h0000, -16'sd100);
    send_xy(-16'sd100, -16'sd1);
    send_xy(-16'sd100, 16'd1);
    send_xy(16'h7FFF, 16'h8000);
    send_xy(16'h8000, 16'h8000);
    send_xy(16'd1, 16'd1);
    wait_drained();

    // Smoothing weight above one freezes the filter; then exactly one, then half.
    reg_write(REG_SMOOTHING, 32'hFFFF);
    send_xy(16'h7FFF, 16'h7FFF);
    send_xy(16'h8000, 16'h1234);
    wait_drained();
    reg_write(REG_SMOOTHING, 32'd32768);
    send_xy(16'h4000, 16'hC000);
    wait_drained();
    reg_write(REG_SMOOTHING, 32'd16384);
    send_xy(16'h7FFF, 16'h8000);
    send_xy(16'h7FFF, 16'h8000);
    wait_drained();
    settings_used += 3;

    // Random settings, each followed by a burst of random samples.
    for (ph = 1; ph <= 12; ph++) begin
      wait_drained();
      new_setting(ph);
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      // Long result-side stall while samples keep coming.
      if (ph == 4) rx_hold_req = 1'b1;
      for (n = 0; n < 155; n++)
        send_xy(pick_axis(cur_off_x), pick_axis(cur_off_y));
    end

    wait_drained();
    repeat (60) @(posedge clk_i);

    $display("Summary: %0d samples under %0d register settings, %0d results checked.",
             samples_sent, settings_used, results);
    $display("Summary: %0d headings computed, %0d calibrate-mode results, %0d mismatches.",
             headings, results - headings, errors);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mhc_pkg.sv
rtl/mhc_regs.sv
rtl/mhc_mul.sv
rtl/mhc_cordic.sv
rtl/magnetometer_heading_correction.sv
tb/magnetometer_heading_checker.sv
tb/magnetometer_heading_correction_tb.sv
